// ===== sv/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// pdc_pkg: shared types and constants for the positional PID controller
// Register map, configuration bundle and fixed-point constants.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int DATA_W   = 16;
    localparam int SUM_W    = 32;
    localparam int LIMIT_W  = 15;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;

    // Register indexes (word address bits of paddr)
    localparam logic [2:0] REG_PROP_GAIN  = 3'd0;
    localparam logic [2:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [2:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [2:0] REG_SEP_LIMIT  = 3'd3;
    localparam logic [2:0] REG_DEAD_BAND  = 3'd4;
    localparam logic [2:0] REG_OUT_MAX    = 3'd5;
    localparam logic [2:0] REG_OUT_MIN    = 3'd6;
    localparam logic [2:0] REG_SEP_MODE   = 3'd7;

    // Reset values
    localparam logic [LIMIT_W-1:0]        SEP_LIMIT_RST = 15'd2560;  // 10.0
    localparam logic [LIMIT_W-1:0]        DEAD_BAND_RST = 15'd128;   // 0.5
    localparam logic signed [DATA_W-1:0]  OUT_MAX_RST   = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0]  OUT_MIN_RST   = 16'sh8000;

    // 0.4 in Q8.8 is 102.4, so a magnitude of 102 or less counts as small
    localparam logic [DATA_W:0] SMALL_ERR_LIMIT = 17'd102;
    // Half an LSB of Q8.8 expressed in Q16.16
    localparam int              ROUND_BIAS      = 128;

    typedef struct packed {
        logic [DATA_W-1:0]         prop_gain;
        logic [DATA_W-1:0]         integ_gain;
        logic [DATA_W-1:0]         deriv_gain;
        logic [LIMIT_W-1:0]        sep_limit;
        logic [LIMIT_W-1:0]        dead_band;
        logic signed [DATA_W-1:0]  out_max;
        logic signed [DATA_W-1:0]  out_min;
        logic                      sep_mode;
    } pdc_cfg_t;

endpackage

// ===== sv/pdc_regs.sv =====
// ----------------------------------------------------------------------------
// pdc_regs: configuration register file
// APB write and read access to the eight controller registers.
// ----------------------------------------------------------------------------
module pdc_regs
    import pdc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [APB_W-1:0]      pwdata,
    output logic [APB_W-1:0]      prdata,
    output logic                  pready,
    output pdc_cfg_t              cfg
);

    pdc_cfg_t   cfg_reg;
    pdc_cfg_t   cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_PROP_GAIN:  cfg_next.prop_gain  = pwdata[DATA_W-1:0];
                REG_INTEG_GAIN: cfg_next.integ_gain = pwdata[DATA_W-1:0];
                REG_DERIV_GAIN: cfg_next.deriv_gain = pwdata[DATA_W-1:0];
                REG_SEP_LIMIT:  cfg_next.sep_limit  = pwdata[LIMIT_W-1:0];
                REG_DEAD_BAND:  cfg_next.dead_band  = pwdata[LIMIT_W-1:0];
                REG_OUT_MAX:    cfg_next.out_max    = $signed(pwdata[DATA_W-1:0]);
                REG_OUT_MIN:    cfg_next.out_min    = $signed(pwdata[DATA_W-1:0]);
                REG_SEP_MODE:   cfg_next.sep_mode   = pwdata[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain  <= '0;
            cfg_reg.integ_gain <= '0;
            cfg_reg.deriv_gain <= '0;
            cfg_reg.sep_limit  <= SEP_LIMIT_RST;
            cfg_reg.dead_band  <= DEAD_BAND_RST;
            cfg_reg.out_max    <= OUT_MAX_RST;
            cfg_reg.out_min    <= OUT_MIN_RST;
            cfg_reg.sep_mode   <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Signed limits read back sign-extended.
    always_comb begin
        case (reg_idx)
            REG_PROP_GAIN:  prdata = {{(APB_W-DATA_W){1'b0}}, cfg_reg.prop_gain};
            REG_INTEG_GAIN: prdata = {{(APB_W-DATA_W){1'b0}}, cfg_reg.integ_gain};
            REG_DERIV_GAIN: prdata = {{(APB_W-DATA_W){1'b0}}, cfg_reg.deriv_gain};
            REG_SEP_LIMIT:  prdata = {{(APB_W-LIMIT_W){1'b0}}, cfg_reg.sep_limit};
            REG_DEAD_BAND:  prdata = {{(APB_W-LIMIT_W){1'b0}}, cfg_reg.dead_band};
            REG_OUT_MAX:    prdata = {{(APB_W-DATA_W){cfg_reg.out_max[DATA_W-1]}},
                                      cfg_reg.out_max};
            REG_OUT_MIN:    prdata = {{(APB_W-DATA_W){cfg_reg.out_min[DATA_W-1]}},
                                      cfg_reg.out_min};
            REG_SEP_MODE:   prdata = {{(APB_W-1){1'b0}}, cfg_reg.sep_mode};
            default:        prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/pdc_core.sv =====
// ----------------------------------------------------------------------------
// pdc_core: PID datapath for one error sample
// Integral update with separation rules, three gain products, rounding,
// dead band hold and output clamp.
// ----------------------------------------------------------------------------
module pdc_core
    import pdc_pkg::*;
(
    input  pdc_cfg_t                   cfg,
    input  logic signed [DATA_W-1:0]   err,
    input  logic signed [SUM_W-1:0]    sum_in,
    input  logic signed [DATA_W-1:0]   prev_err,
    input  logic signed [DATA_W-1:0]   prev_out,
    output logic signed [SUM_W-1:0]    sum_next,
    output logic signed [DATA_W-1:0]   drive
);

    localparam int ACC_W = 52;
    localparam int RES_W = ACC_W - 8;

    logic signed [DATA_W:0]     err_ext;
    logic [DATA_W:0]            err_mag;
    logic                       err_small;
    logic                       err_over;
    logic                       do_accum;
    logic signed [SUM_W:0]      sum_wide;
    logic signed [DATA_W:0]     err_diff;
    logic signed [32:0]         p_prod;
    logic signed [48:0]         i_prod;
    logic signed [33:0]         d_prod;
    logic signed [ACC_W-1:0]    acc;
    logic signed [RES_W-1:0]    res;

    assign err_ext   = {err[DATA_W-1], err};
    assign err_mag   = err_ext[DATA_W] ? (DATA_W+1)'(-err_ext) : err_ext;
    assign err_small = err_mag <= SMALL_ERR_LIMIT;
    assign err_over  = err_mag > {2'b00, cfg.sep_limit};

    // With separation on, an output stuck beyond a limit lets through only
    // errors that drive it back inside.
    always_comb begin
        if (cfg.sep_mode) begin
            if (prev_out > cfg.out_max) begin
                do_accum = err[DATA_W-1];
            end else if (prev_out < cfg.out_min) begin
                do_accum = !err[DATA_W-1] && (err != '0)
                           && (err[DATA_W-2:0] <= cfg.sep_limit);
            end else begin
                do_accum = !(err_over || err_small);
            end
        end else begin
            do_accum = !err_small;
        end
    end

    always_comb begin
        sum_wide = {sum_in[SUM_W-1], sum_in} + (SUM_W+1)'(err);
        if (!do_accum) begin
            sum_next = sum_in;
        end else if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
            sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                       : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
            sum_next = sum_wide[SUM_W-1:0];
        end
    end

    assign err_diff = err_ext - {prev_err[DATA_W-1], prev_err};
    assign p_prod   = $signed({1'b0, cfg.prop_gain})  * err;
    assign i_prod   = $signed({1'b0, cfg.integ_gain}) * sum_next;
    assign d_prod   = $signed({1'b0, cfg.deriv_gain}) * err_diff;

    assign acc = ACC_W'(p_prod) + ACC_W'(i_prod) + ACC_W'(d_prod)
               + ACC_W'(ROUND_BIAS);

    // Arithmetic shift floors, which gives round-half-up to Q8.8.
    always_comb begin
        if (err_mag < {2'b00, cfg.dead_band}) begin
            res = RES_W'(prev_out);
        end else begin
            res = acc[ACC_W-1:8];
        end
        if (res > RES_W'(cfg.out_max)) begin
            res = RES_W'(cfg.out_max);
        end
        if (res < RES_W'(cfg.out_min)) begin
            res = RES_W'(cfg.out_min);
        end
    end

    assign drive = res[DATA_W-1:0];

endmodule

// ===== sv/positional_pid_deadband_clamp.sv =====
// ----------------------------------------------------------------------------
// positional_pid_deadband_clamp: positional PID with integral separation
// Q8.8 controller with saturating integral, dead band and output clamp.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tdata[15:0] error_sample
//  m_axis    out        tdata[15:0] drive_out
//  apb       in/out     eight 32-bit registers at byte address 4*index
//
//  One transaction per cycle is sustained while the output is not stalled;
//  a result passes through the input register and then the result register.
//  The cycle is set by the integral update feeding the 16x32 integral
//  product, the adder and the clamp, all in the loop through the state.
//  Reset clears the controller state and both valid flags.
//  A stalled result holds; the input register still takes one more sample.
// ----------------------------------------------------------------------------
module positional_pid_deadband_clamp
    import pdc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [15:0]        s_axis_tdata,   // [15:0] error_sample
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [15:0]        m_axis_tdata,   // [15:0] drive_out
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready
);

    pdc_cfg_t                  cfg;

    logic                      in_valid_reg,  in_valid_next;
    logic signed [DATA_W-1:0]  in_err_reg,    in_err_next;
    logic                      out_valid_reg, out_valid_next;
    logic signed [DATA_W-1:0]  out_data_reg,  out_data_next;
    logic signed [SUM_W-1:0]   sum_reg,       sum_next;
    logic signed [DATA_W-1:0]  prev_err_reg,  prev_err_next;
    logic signed [DATA_W-1:0]  prev_out_reg,  prev_out_next;

    logic signed [SUM_W-1:0]   core_sum;
    logic signed [DATA_W-1:0]  core_drive;
    logic                      s_accept;
    logic                      advance;

    pdc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pdc_core u_core (
        .cfg      (cfg),
        .err      (in_err_reg),
        .sum_in   (sum_reg),
        .prev_err (prev_err_reg),
        .prev_out (prev_out_reg),
        .sum_next (core_sum),
        .drive    (core_drive)
    );

    // A sample moves into the result register whenever that register is
    // free or being emptied in the same cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_valid_next  = s_accept || (in_valid_reg && !advance);
        in_err_next    = s_accept ? $signed(s_axis_tdata) : in_err_reg;
        out_valid_next = advance || (out_valid_reg && !m_axis_tready);
        out_data_next  = advance ? core_drive : out_data_reg;
        sum_next       = advance ? core_sum   : sum_reg;
        prev_err_next  = advance ? in_err_reg : prev_err_reg;
        prev_out_next  = advance ? core_drive : prev_out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            prev_err_reg  <= '0;
            prev_out_reg  <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            sum_reg       <= sum_next;
            prev_err_reg  <= prev_err_next;
            prev_out_reg  <= prev_out_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_err_reg   <= in_err_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // The stored previous output is the value just presented.
    a_prev_matches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (prev_out_reg == out_data_reg))
        else $error("previous output register differs from presented result");

    // A full input register behind a stalled result must not take more.
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while both stages are blocked");

    // Each sample that moves on produces a presented result.
    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_axis_tvalid)
        else $error("advanced sample produced no result");

    // State only changes when a sample moves on.
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> ($stable(sum_reg) && $stable(prev_err_reg)))
        else $error("controller state changed without a transaction");
`endif

endmodule

// ===== sim/positional_pid_deadband_clamp_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_pid_deadband_clamp_test: self-checking bench for the PID block
// Error samples are streamed in and each drive_out is checked against a
// cycle-free predictor of the controller. The predictor covers the separation
// rules, the dead band, Q16.16 rounding, the clamp and the accumulator
// saturation. Registers are set over APB between phases and read back.
// ----------------------------------------------------------------------------
module positional_pid_deadband_clamp_test;
    import pdc_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [15:0]        s_axis_tdata = '0;   // [15:0] error_sample
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [15:0]        m_axis_tdata;        // [15:0] drive_out
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [APB_W-1:0]   pwdata = '0;
    logic [APB_W-1:0]   prdata;
    logic               pready;

    positional_pid_deadband_clamp dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Controller copy used for prediction
    pdc_cfg_t                   ctrl_cfg;
    logic signed [SUM_W-1:0]    integ_sum;
    logic signed [DATA_W-1:0]   last_err;
    logic signed [DATA_W-1:0]   last_drive;

    logic [15:0]                error_queue[$];
    logic signed [DATA_W-1:0]   expected_drive[$];
    logic signed [DATA_W-1:0]   want_drive;

    int     error_count = 0;
    int     samples_sent = 0;
    int     results_seen = 0;
    int     register_writes = 0;
    int     sat_hits = 0;
    int     windup_items = 0;
    int     deadband_items = 0;
    int     send_gap = 0;
    int     stall_left = 0;
    int     hold_left = 0;
    int     hold_requests = 0;
    int     hold_served = 0;
    logic   tx_idle_on = 1'b0;
    logic   rx_idle_on = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // One controller step: integral update, output, clamp, state update.
    function automatic logic signed [DATA_W-1:0] pid_step(input logic signed [DATA_W-1:0] err);
        longint e, ae, sum, acc, res, sep, db, omax, omin, kp, ki, kd, pd;
        logic   add_it;
        e    = err;
        ae   = (e < 0) ? -e : e;
        sep  = ctrl_cfg.sep_limit;
        db   = ctrl_cfg.dead_band;
        omax = $signed(ctrl_cfg.out_max);
        omin = $signed(ctrl_cfg.out_min);
        kp   = ctrl_cfg.prop_gain;
        ki   = ctrl_cfg.integ_gain;
        kd   = ctrl_cfg.deriv_gain;
        pd   = last_drive;
        sum  = integ_sum;

        if (ctrl_cfg.sep_mode) begin
            if (pd > omax) begin
                add_it = (e <= sep) && (e < 0);
                windup_items++;
            end else if (pd < omin) begin
                add_it = (e <= sep) && (e > 0);
                windup_items++;
            end else begin
                add_it = !(ae > sep || ae <= longint'(SMALL_ERR_LIMIT));
            end
        end else begin
            add_it = ae > longint'(SMALL_ERR_LIMIT);
        end

        if (add_it) begin
            sum = sum + e;
            if (sum > 64'sd2147483647) begin
                sum = 64'sd2147483647;
                sat_hits++;
            end
            if (sum < -64'sd2147483648) begin
                sum = -64'sd2147483648;
                sat_hits++;
            end
        end

        if (ae < db) begin
            res = pd;
            deadband_items++;
        end else begin
            acc = kp * e + ki * sum + kd * (e - longint'(last_err));
            // Arithmetic shift gives the floor, as the rounding rule requires
            res = (acc + ROUND_BIAS) >>> 8;
        end

        if (res > omax) res = omax;
        if (res < omin) res = omin;

        integ_sum  = sum[SUM_W-1:0];
        last_err   = err;
        last_drive = res[DATA_W-1:0];
        return last_drive;
    endfunction

    function automatic logic [31:0] register_mask(input logic [2:0] idx);
        case (idx)
            REG_SEP_LIMIT, REG_DEAD_BAND: return 32'h0000_7FFF;
            REG_SEP_MODE:                 return 32'h0000_0001;
            default:                      return 32'h0000_FFFF;
        endcase
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [31:0] value);
        case (idx)
            REG_PROP_GAIN:  ctrl_cfg.prop_gain  = value[15:0];
            REG_INTEG_GAIN: ctrl_cfg.integ_gain = value[15:0];
            REG_DERIV_GAIN: ctrl_cfg.deriv_gain = value[15:0];
            REG_SEP_LIMIT:  ctrl_cfg.sep_limit  = value[14:0];
            REG_DEAD_BAND:  ctrl_cfg.dead_band  = value[14:0];
            REG_OUT_MAX:    ctrl_cfg.out_max    = value[15:0];
            REG_OUT_MIN:    ctrl_cfg.out_min    = value[15:0];
            REG_SEP_MODE:   ctrl_cfg.sep_mode   = value[0];
            default: ;
        endcase
    endfunction

    // A setup cycle, then an access cycle that waits for pready.
    task automatic apb_access(input logic [2:0] idx, input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Unused upper bits carry junk, which the block must drop.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] mask;
        logic [31:0] rdata;
        mask = register_mask(idx);
        apb_access(idx, 1'b1, (value & mask) | ($urandom & ~mask), rdata);
        apply_register(idx, value);
        register_writes++;
        apb_access(idx, 1'b0, '0, rdata);
        if ((rdata & mask) !== (value & mask)) begin
            error_count++;
            $display("%0t: register %0d read back: expected %h actual %h", $time, idx,
                     value & mask, rdata & mask);
        end
    endtask

    task automatic write_limits(input int omax, input int omin);
        write_register(REG_OUT_MAX, omax);
        write_register(REG_OUT_MIN, omin);
    endtask

    // Block is idle once every sample has gone in and every result come out.
    task automatic wait_drained();
        while (error_queue.size() != 0 || s_axis_tvalid || expected_drive.size() != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic send_samples(input int values[]);
        foreach (values[i]) error_queue.push_back(16'(values[i]));
        wait_drained();
    endtask

    function automatic logic [15:0] draw_error();
        int v;
        int db;
        int sl;
        logic [31:0] raw;
        db  = ctrl_cfg.dead_band;
        sl  = ctrl_cfg.sep_limit;
        raw = $urandom;
        case ($urandom_range(0, 9))
            0, 1, 2: return raw[15:0];
            3:       v = $urandom_range(0, 400) - 200;
            4:       v = db - 3 + $urandom_range(0, 6);
            5:       v = sl - 3 + $urandom_range(0, 6);
            6: begin
                case ($urandom_range(0, 3))
                    0: v = 32767;
                    1: v = -32768;
                    2: v = -32767;
                    default: v = 0;
                endcase
            end
            default: v = $urandom_range(0, 6000) - 3000;
        endcase
        if (raw[31] && v != -32768) v = -v;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic logic [31:0] draw_gain();
        case ($urandom_range(0, 4))
            0: return 32'h0;
            1: return 32'hFFFF;
            2: return $urandom;
            default: return $urandom_range(0, 1024);
        endcase
    endfunction

    task automatic randomise_settings();
        int lo;
        int hi;
        int t;
        write_register(REG_PROP_GAIN, draw_gain());
        write_register(REG_INTEG_GAIN, draw_gain());
        write_register(REG_DERIV_GAIN, draw_gain());
        case ($urandom_range(0, 3))
            0: write_register(REG_SEP_LIMIT, 0);
            1: write_register(REG_SEP_LIMIT, 32767);
            default: write_register(REG_SEP_LIMIT, $urandom_range(0, 6000));
        endcase
        case ($urandom_range(0, 7))
            0: write_register(REG_DEAD_BAND, 0);
            1: write_register(REG_DEAD_BAND, 32767);
            default: write_register(REG_DEAD_BAND, $urandom_range(0, 600));
        endcase
        lo = $urandom_range(0, 32767) - 32768;
        hi = $urandom_range(0, 32767);
        case ($urandom_range(0, 5))
            0: write_limits(32767, -32768);
            1: write_limits(lo + 32767, hi - 32767);   // upper limit from -1 up, lower limit up to 0
            2: write_limits($urandom_range(0, 2000), -$urandom_range(0, 2000));
            default: begin
                if (lo > hi) begin
                    t = lo;
                    lo = hi;
                    hi = t;
                end
                write_limits(hi, lo);
            end
        endcase
        write_register(REG_SEP_MODE, $urandom_range(0, 1));
    endtask

    // Sender: one sample per transaction, with a drawn gap after each while idling is on.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_drive.push_back(pid_step(s_axis_tdata));
                samples_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (error_queue.size() > 0) begin
                    s_axis_tdata  <= error_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    send_gap = tx_idle_on ? $urandom_range(0, 7) : 0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result, stalls at random, holds off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (expected_drive.size() == 0) begin
                    error_count++;
                    $display("%0t: drive_out expected none, actual %0d", $time,
                             $signed(m_axis_tdata));
                end else begin
                    want_drive = expected_drive.pop_front();
                    if (m_axis_tdata !== want_drive) begin
                        error_count++;
                        $display("%0t: drive_out expected %0d, actual %0d", $time,
                                 want_drive, $signed(m_axis_tdata));
                    end
                end
                stall_left = rx_idle_on ? $urandom_range(0, 7) : 0;
            end
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = 250;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        ctrl_cfg.prop_gain  = '0;
        ctrl_cfg.integ_gain = '0;
        ctrl_cfg.deriv_gain = '0;
        ctrl_cfg.sep_limit  = SEP_LIMIT_RST;
        ctrl_cfg.dead_band  = DEAD_BAND_RST;
        ctrl_cfg.out_max    = OUT_MAX_RST;
        ctrl_cfg.out_min    = OUT_MIN_RST;
        ctrl_cfg.sep_mode   = 1'b1;
        integ_sum  = '0;
        last_err   = '0;
        last_drive = '0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: zero gains, so the output stays at zero.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_samples('{4096, -4096, 50});

        write_register(REG_PROP_GAIN, 256);
        write_register(REG_INTEG_GAIN, 8);
        write_register(REG_DERIV_GAIN, 128);
        write_register(REG_SEP_LIMIT, 2560);
        write_register(REG_DEAD_BAND, 128);
        write_limits(4096, -4096);
        write_register(REG_SEP_MODE, 1);

        // Small-error, dead band and separation boundaries, then the extremes.
        send_samples('{0, 100, -100, 102, -102, 103, -103, 127, 128, -128,
                       2560, -2560, 2561, -2561, 32767, -32768, 32767});

        // Previous output above the upper limit: only opposing errors integrate.
        write_register(REG_OUT_MAX, 1024);
        send_samples('{-500, 3000});
        write_register(REG_OUT_MAX, 4096);
        send_samples('{-32768});
        // Previous output below the lower limit.
        write_register(REG_OUT_MIN, -1024);
        send_samples('{500, -3000});
        // Inverted limits keep the lower limit, so the windup rule persists.
        write_limits(-256, 256);
        send_samples('{3000, -3000, -500, 500});
        write_register(REG_SEP_MODE, 0);
        send_samples('{50, -50, 103, 20000});

        for (int phase = 0; phase < 20; phase++) begin
            randomise_settings();
            tx_idle_on = phase[0];
            rx_idle_on = phase[1] | phase[2];
            for (int n = 0; n < 80; n++) error_queue.push_back(draw_error());
            if (phase == 4 || phase == 13) hold_requests++;
            wait_drained();
        end

        // Full-scale errors of both signs at the largest integral gain, no idling.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_register(REG_PROP_GAIN, 0);
        write_register(REG_INTEG_GAIN, 16'hFFFF);
        write_register(REG_DERIV_GAIN, 0);
        write_register(REG_DEAD_BAND, 0);
        write_limits(32767, -32768);
        write_register(REG_SEP_MODE, 0);
        for (int n = 0; n < 20; n++) error_queue.push_back(16'h7FFF);
        for (int n = 0; n < 20; n++) error_queue.push_back(16'h8000);
        for (int n = 0; n < 20; n++) error_queue.push_back(draw_error());
        wait_drained();
        repeat (10) @(negedge aclk);

        $display("Checked %0d results from %0d samples across %0d register writes.",
                 results_seen, samples_sent, register_writes);
        $display("Dead band held %0d times, windup rule applied %0d times, %0d saturations.",
                 deadband_items, windup_items, sat_hits);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
